### rtl/core/ebf_pkg.sv
// ----------------------------------------------------------------------------
// ebf_pkg - shared types and constants
// Constants, job word and state types used by the edge-normalised box filter.
// ----------------------------------------------------------------------------
package ebf_pkg;

  localparam int MAX_RADIUS  = 7;
  localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int SAMPLE_W    = 8;
  localparam int RADIUS_W    = 3;
  localparam int COUNT_W     = 4;   // holds 1 .. STORE_DEPTH
  localparam int SUM_W       = 12;  // STORE_DEPTH * 255 fits

  // divider: quotient bits resolved per clock, and rounds per division
  localparam int DIV_BITS_PER_ROUND = 4;
  localparam int DIV_ROUNDS         = SUM_W / DIV_BITS_PER_ROUND;
  localparam int ROUND_W            = 2;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // one division job: window sum, neighbour count, end-of-line mark
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] cnt;
    logic               last;
  } job_t;

  typedef enum logic {
    FE_RUN,
    FE_FLUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

### rtl/core/ebf_front.sv
// ----------------------------------------------------------------------------
// ebf_front - window tracking and job issue
// Keeps the sample shift line and running sum, turns each accepted word into
// division jobs, and walks the end-of-line flush one job per unstalled cycle.
// ----------------------------------------------------------------------------
module ebf_front (
  input  logic                          clk,
  input  logic                          rst,
  // sample words
  input  logic                          push,
  output logic                          full,
  input  logic [ebf_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          end_of_line,
  // radius register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ebf_pkg::RADIUS_W-1:0]  cfg_data,
  // jobs to queue
  output logic                          job_push,
  input  logic                          job_full,
  output ebf_pkg::job_t                 job
);

  ebf_pkg::front_state_t state, state_next;

  logic [ebf_pkg::RADIUS_W-1:0] radius;
  logic [ebf_pkg::SAMPLE_W-1:0] store [ebf_pkg::STORE_DEPTH];
  logic [ebf_pkg::COUNT_W-1:0]  seen;
  logic [ebf_pkg::SUM_W-1:0]    sum;
  logic [ebf_pkg::RADIUS_W-1:0] d;
  logic [ebf_pkg::COUNT_W-1:0]  hi;

  logic                         accept;
  logic                         cfg_wr;
  logic                         flush_step;
  logic [ebf_pkg::COUNT_W-1:0]  span;
  logic [ebf_pkg::COUNT_W-1:0]  rd_addr;
  logic [ebf_pkg::SAMPLE_W-1:0] rd_data;
  logic [ebf_pkg::COUNT_W-1:0]  seen_inc;
  logic [ebf_pkg::SUM_W-1:0]    sum_new;
  logic [ebf_pkg::COUNT_W-1:0]  cnt_run;
  logic [ebf_pkg::COUNT_W-1:0]  seen_m1;
  logic [ebf_pkg::RADIUS_W-1:0] dmax;
  logic [ebf_pkg::COUNT_W-1:0]  hi0;
  logic [ebf_pkg::COUNT_W-1:0]  hi0_raw;
  logic [ebf_pkg::RADIUS_W-1:0] d_dec;
  logic [ebf_pkg::COUNT_W-1:0]  hi_raw;
  logic [ebf_pkg::COUNT_W-1:0]  hi_f;
  logic [ebf_pkg::COUNT_W-1:0]  seen_reg_m1;
  logic [ebf_pkg::SUM_W-1:0]    fsum;

  assign span    = {radius, 1'b1};
  // single read tap: outgoing sample in a run, trailing edge during a flush
  assign rd_addr = (state == ebf_pkg::FE_FLUSH) ? hi : span - 4'd1;
  assign rd_data = store[rd_addr];

  // run-time datapath
  assign seen_inc = (seen == ebf_pkg::COUNT_W'(ebf_pkg::STORE_DEPTH)) ? seen : seen + 4'd1;
  assign sum_new  = sum - ((seen >= span) ? {4'd0, rd_data} : '0) + {4'd0, sample};
  assign cnt_run  = (seen_inc < span) ? seen_inc : span;
  assign seen_m1  = seen_inc - 4'd1;
  assign dmax     = (seen_m1 < {1'b0, radius}) ? seen_m1[ebf_pkg::RADIUS_W-1:0] : radius;
  assign hi0_raw  = {1'b0, dmax} + {1'b0, radius};
  assign hi0      = (hi0_raw < seen_m1) ? hi0_raw : seen_m1;

  // flush datapath: window end stays clipped, then shrinks by one each step
  assign d_dec       = d - 3'd1;
  assign seen_reg_m1 = seen - 4'd1;
  assign hi_raw      = {1'b0, d_dec} + {1'b0, radius};
  assign hi_f        = (hi_raw < seen_reg_m1) ? hi_raw : seen_reg_m1;
  assign fsum        = sum - ((hi_f < hi) ? {4'd0, rd_data} : '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ebf_pkg::FE_RUN: begin
        if (accept && end_of_line && (dmax != '0)) state_next = ebf_pkg::FE_FLUSH;
      end
      ebf_pkg::FE_FLUSH: begin
        if (!job_full && (d_dec == '0)) state_next = ebf_pkg::FE_RUN;
      end
      default: state_next = ebf_pkg::FE_RUN;
    endcase
  end

  // outputs
  always_comb begin
    full       = 1'b1;
    cfg_ready  = 1'b0;
    flush_step = 1'b0;
    job_push   = 1'b0;
    job        = '0;
    case (state)
      ebf_pkg::FE_RUN: begin
        full      = job_full;
        cfg_ready = 1'b1;
        job_push  = push && !job_full && (end_of_line || (seen_inc > {1'b0, radius}));
        if (end_of_line) begin
          job.sum  = sum_new;
          job.cnt  = hi0 + 4'd1;
          job.last = (dmax == '0);
        end else begin
          job.sum  = sum_new;
          job.cnt  = cnt_run;
          job.last = 1'b0;
        end
      end
      ebf_pkg::FE_FLUSH: begin
        flush_step = !job_full;
        job_push   = !job_full;
        job.sum    = fsum;
        job.cnt    = hi_f + 4'd1;
        job.last   = (d_dec == '0);
      end
      default: begin
        full = 1'b1;
      end
    endcase
  end

  assign accept = push && !full;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ebf_pkg::FE_RUN;
      radius <= 3'd2;
      seen   <= '0;
      sum    <= '0;
      d      <= '0;
      hi     <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        radius <= cfg_data;
        seen   <= '0;
        sum    <= '0;
      end else if (accept) begin
        if (end_of_line && (dmax == '0)) begin
          seen <= '0;
          sum  <= '0;
        end else begin
          seen <= seen_inc;
          sum  <= sum_new;
        end
        d  <= dmax;
        hi <= hi0;
      end else if (flush_step) begin
        d  <= d_dec;
        hi <= hi_f;
        if (d_dec == '0) begin
          seen <= '0;
          sum  <= '0;
        end else begin
          sum <= fsum;
        end
      end
    end
  end

  // sample shift line, newest at entry 0
  always_ff @(posedge clk) begin
    if (accept) begin
      store[0] <= sample;
      for (int k = 1; k < ebf_pkg::STORE_DEPTH; k++) begin
        store[k] <= store[k-1];
      end
    end
  end

endmodule

### rtl/core/ebf_queue.sv
// ----------------------------------------------------------------------------
// ebf_queue - job queue
// Short first-in first-out store decoupling the front from the divider.
// ----------------------------------------------------------------------------
module ebf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  ebf_pkg::job_t wr_job,
  output logic          q_full,
  input  logic          rd,
  output ebf_pkg::job_t rd_job,
  output logic          q_empty
);

  ebf_pkg::job_t mem [ebf_pkg::QUEUE_DEPTH];

  logic [ebf_pkg::QPTR_W-1:0] wptr;
  logic [ebf_pkg::QPTR_W-1:0] rptr;
  logic [ebf_pkg::QCNT_W-1:0] count;
  logic                       do_wr;
  logic                       do_rd;

  assign q_full  = (count == ebf_pkg::QCNT_W'(ebf_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_job  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_job;
  end

endmodule

### rtl/core/ebf_back.sv
// ----------------------------------------------------------------------------
// ebf_back - divider and result register
// Restoring divider, four quotient bits a clock, feeding a one-word output.
// ----------------------------------------------------------------------------
module ebf_back (
  input  logic                         clk,
  input  logic                         rst,
  // jobs from queue
  input  ebf_pkg::job_t                job,
  input  logic                         job_empty,
  output logic                         job_pop,
  // result words
  output logic                         empty,
  input  logic                         pop,
  output logic [ebf_pkg::SAMPLE_W-1:0] average,
  output logic                         last_of_line
);

  ebf_pkg::back_state_t state, state_next;

  logic [ebf_pkg::ROUND_W-1:0] round;
  logic [ebf_pkg::COUNT_W:0]   rem;
  logic [ebf_pkg::SUM_W-1:0]   quo;
  logic [ebf_pkg::COUNT_W-1:0] divisor;
  logic                        last_b;
  logic                        out_valid;

  logic [ebf_pkg::COUNT_W:0]   rem_t;
  logic [ebf_pkg::COUNT_W:0]   sh;
  logic [ebf_pkg::SUM_W-1:0]   quo_t;
  logic                        out_free;
  logic                        load_out;
  logic                        start;
  logic                        div_run;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // one round of the restoring divider
  always_comb begin
    rem_t = rem;
    quo_t = quo;
    for (int i = 0; i < ebf_pkg::DIV_BITS_PER_ROUND; i++) begin
      sh    = {rem_t[ebf_pkg::COUNT_W-1:0], quo_t[ebf_pkg::SUM_W-1]};
      quo_t = {quo_t[ebf_pkg::SUM_W-2:0], 1'b0};
      if (sh >= {1'b0, divisor}) begin
        rem_t    = sh - {1'b0, divisor};
        quo_t[0] = 1'b1;
      end else begin
        rem_t = sh;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ebf_pkg::BK_IDLE: begin
        if (!job_empty) state_next = ebf_pkg::BK_DIV;
      end
      ebf_pkg::BK_DIV: begin
        if (round == ebf_pkg::ROUND_W'(ebf_pkg::DIV_ROUNDS - 1)) state_next = ebf_pkg::BK_DONE;
      end
      ebf_pkg::BK_DONE: begin
        if (out_free) state_next = ebf_pkg::BK_IDLE;
      end
      default: state_next = ebf_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    start    = 1'b0;
    div_run  = 1'b0;
    load_out = 1'b0;
    case (state)
      ebf_pkg::BK_IDLE: start    = !job_empty;
      ebf_pkg::BK_DIV:  div_run  = 1'b1;
      ebf_pkg::BK_DONE: load_out = out_free;
      default:          start    = 1'b0;
    endcase
  end

  assign job_pop = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ebf_pkg::BK_IDLE;
      round     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start)   round <= '0;
      if (div_run) round <= round + 1'b1;
      if (load_out)                out_valid <= 1'b1;
      else if (pop && out_valid)   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= job.sum;
      divisor <= job.cnt;
      last_b  <= job.last;
    end
    if (div_run) begin
      rem <= rem_t;
      quo <= quo_t;
    end
    if (load_out) begin
      average      <= quo[ebf_pkg::SAMPLE_W-1:0];
      last_of_line <= last_b;
    end
  end

endmodule

### rtl/core/edge_normalized_box_filter_top.sv
// ----------------------------------------------------------------------------
// edge_normalized_box_filter_top - centred moving average over a luma line
// Box filter of radius R whose window is clipped and renormalised at both
// ends of the line; results lag the input by R samples.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------
//  input     push / full            sample[7:0], end_of_line
//  result    empty / pop            average[7:0], last_of_line
//  config    cfg_valid / cfg_ready  cfg_data[2:0] (filter radius)
//
//  Front takes one word a clock while the job queue (4 deep) has room. Each
//  job takes the divider through start, 3 rounds of 4 quotient bits and hand
//  over; the divider starts the next job only once it has handed one over.
//  An end-of-line word releases up to R more jobs, one a clock while the queue
//  has room; full stays high while they are issued.
//  Reset (rst, synchronous) sets the radius to 2 and empties the line state.
//  Writing the radius drops any partial line. A waiting result lets the
//  divider finish one more quotient and then holds it; a full queue or an
//  end-of-line flush stops the front.
//
module edge_normalized_box_filter_top (
  input  logic       clk,
  input  logic       rst,
  // input words
  input  logic       push,
  output logic       full,
  input  logic [7:0] sample,
  input  logic       end_of_line,
  // result words
  output logic       empty,
  input  logic       pop,
  output logic [7:0] average,
  output logic       last_of_line,
  // radius register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  ebf_pkg::job_t f_job;
  ebf_pkg::job_t q_job;
  logic          f_push;
  logic          q_full;
  logic          q_empty;
  logic          b_pop;

  // window tracking, issues one job per result word
  ebf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample      (sample),
    .end_of_line (end_of_line),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .job_push    (f_push),
    .job_full    (q_full),
    .job         (f_job)
  );

  // decouples the front from the divider
  ebf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_job  (f_job),
    .q_full  (q_full),
    .rd      (b_pop),
    .rd_job  (q_job),
    .q_empty (q_empty)
  );

  // sum / count and the result register
  ebf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (q_job),
    .job_empty    (q_empty),
    .job_pop      (b_pop),
    .empty        (empty),
    .pop          (pop),
    .average      (average),
    .last_of_line (last_of_line)
  );

endmodule

### tb/sv/edge_normalized_box_filter_top_test.sv
// ----------------------------------------------------------------------------
// edge_normalized_box_filter_top_test - self-checking bench for the box filter
// Streams luma lines through the filter with random sender bursts and receiver
// stalls. Every result word is checked in order against a line-level
// prediction of the clipped, renormalised window average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_normalized_box_filter_top_test;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int          SETTLE      = 60;    // divider and flush drain time
  localparam int          PHASES      = 7;
  localparam int          PHASE_WORDS = 26;

  typedef logic [ebf_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t average;
    logic    last;
  } avg_word_t;

  typedef enum logic [1:0] {
    POP_FREE,
    POP_COIN,
    POP_SLOW,
    POP_BURSTY
  } pop_mode_t;

  // Tracks the current line and holds the averages it is due to produce.
  class line_average_tracker;
    logic [ebf_pkg::RADIUS_W-1:0] radius;
    sample_t                      line_store [ebf_pkg::STORE_DEPTH];  // entry 0 newest
    int unsigned                  seen_in_line;              // saturates at STORE_DEPTH
    int unsigned                  running_sum;
    avg_word_t                    averages_due [$];
    int unsigned                  mismatches;
    int unsigned                  averages_checked;

    function new();
      mismatches       = 0;
      averages_checked = 0;
      set_radius(3'd2);
    endfunction

    // a radius write drops any partial line
    function void set_radius(logic [ebf_pkg::RADIUS_W-1:0] r);
      radius       = r;
      seen_in_line = 0;
      running_sum  = 0;
    endfunction

    function int unsigned pending();
      return averages_due.size();
    endfunction

    function void take_sample(sample_t s, logic eol);
      int unsigned r;
      int unsigned span;
      int unsigned cnt;
      int unsigned hi;
      int unsigned acc;
      int          dmax;
      avg_word_t   w;
      r    = radius;  // 3 bits never exceed MAX_RADIUS
      span = 2 * r + 1;
      if (seen_in_line >= span) running_sum -= line_store[span-1];
      for (int k = ebf_pkg::STORE_DEPTH - 1; k > 0; k--) line_store[k] = line_store[k-1];
      line_store[0] = s;
      running_sum  += s;
      if (seen_in_line < ebf_pkg::STORE_DEPTH) seen_in_line++;
      if (!eol) begin
        if (seen_in_line > r) begin
          cnt       = (seen_in_line < span) ? seen_in_line : span;
          w.average = sample_t'(running_sum / cnt);
          w.last    = 1'b0;
          averages_due = {averages_due, w};
        end
        return;
      end
      // end of line: release the lagging outputs, oldest first
      dmax = ((seen_in_line - 1) < r) ? (seen_in_line - 1) : r;
      for (int d = dmax; d >= 0; d--) begin
        hi = d + r;
        if (hi > seen_in_line - 1) hi = seen_in_line - 1;
        acc = 0;
        for (int k = 0; k <= hi; k++) acc += line_store[k];
        w.average = sample_t'(acc / (hi + 1));
        w.last    = (d == 0);
        averages_due = {averages_due, w};
      end
      seen_in_line = 0;
      running_sum  = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at result %0d: %s", averages_checked, msg);
      mismatches++;
    endtask

    task check_average(sample_t avg, logic last);
      avg_word_t want;
      if (averages_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word average=%0d last=%0b", avg, last));
        return;
      end
      want = averages_due.pop_front();
      if (avg !== want.average)
        report_mismatch($sformatf("average %0d, want %0d", avg, want.average));
      if (last !== want.last)
        report_mismatch($sformatf("last_of_line %0b, want %0b", last, want.last));
      averages_checked++;
    endtask
  endclass

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       push        = 1'b0;
  logic       full;
  logic [7:0] sample      = '0;
  logic       end_of_line = 1'b0;
  logic       empty;
  logic       pop         = 1'b0;
  logic [7:0] average;
  logic       last_of_line;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data    = '0;

  line_average_tracker tracker = new();

  // sender burst state
  int unsigned burst_left = 0;
  bit          gapless    = 1'b0;

  // receiver pattern state
  pop_mode_t   pop_mode    = POP_FREE;
  bit [6:0]    pattern_age = '0;
  int unsigned stall_left  = 0;

  int unsigned cycle_count = 0;

  edge_normalized_box_filter_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .end_of_line  (end_of_line),
    .empty        (empty),
    .pop          (pop),
    .average      (average),
    .last_of_line (last_of_line),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("edge_normalized_box_filter_top regression: fail");
      $finish;
    end
  end

  // Receiver: pop pattern is redrawn each time pattern_age wraps. Bursty mode holds
  // pop low (or high) until a randomly drawn stall count runs out, then toggles it.
  always @(negedge clk) begin
    if (pattern_age == 0) pop_mode = pop_mode_t'($urandom_range(0, 3));
    pattern_age++;
    case (pop_mode)
      POP_FREE: pop <= 1'b1;
      POP_COIN: pop <= 1'($urandom_range(0, 1));
      POP_SLOW: pop <= ($urandom_range(0, 7) == 0);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
        end else begin
          stall_left = $urandom_range(1, 30);
          pop <= ~pop;
        end
      end
    endcase
  end

  // Result words are taken on the rising edge, pre-edge values.
  always @(posedge clk) begin
    if (!rst && pop && !empty) tracker.check_average(average, last_of_line);
  end

  // push low; n sets the length of the pause
  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // One input word; a burst keeps push high from word to word.
  task automatic send_word(logic [7:0] s, logic eol);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!gapless) pause_sender($urandom_range(0, 8));
    end
    burst_left--;
    @(negedge clk);
    push        <= 1'b1;
    sample      <= s;
    end_of_line <= eol;
    do @(posedge clk); while (full);
    tracker.take_sample(s, eol);
  endtask

  // Wait for every due word, then let the divider and flush settle.
  task automatic drain();
    pause_sender(1);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_radius(logic [2:0] r);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_radius(r);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly random, with a fair share of black and white extremes.
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [2:0] phase_radius [PHASES] = '{3'd7, 3'd0, 3'd3, 3'd1, 3'd6, 3'd4, 3'd5};
    int         left;
    int         len;
    bit         closed;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset radius 2, single-sample line, then a short line
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b1);
    drain();

    // radius 0: output is the sample itself
    write_radius(3'd0);
    send_word(8'd17, 1'b0);
    send_word(8'd200, 1'b1);
    // leave a line open, then change the radius mid-line to drop it
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    drain();

    // largest radius, line long enough to fill and slide the whole window
    write_radius(3'd7);
    for (int i = 0; i < 16; i++) send_word((i % 2) ? 8'hFF : 8'h00, i == 15);

    // Random phases: lines of random length, the last one sometimes left open
    // so the following radius write lands mid-line. drain() is the point
    // where the sender holds off until every due word has come back.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_radius(p == PHASES - 1 ? 3'($urandom_range(0, 7)) : phase_radius[p]);
      gapless = ($urandom_range(0, 3) == 0);
      left    = PHASE_WORDS;
      while (left > 0) begin
        len    = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        closed = 1'b1;
        if (len > left) begin
          len    = left;
          closed = 1'($urandom_range(0, 1));
        end
        for (int i = 0; i < len; i++) send_word(pick_sample(), closed && (i == len - 1));
        left -= len;
      end
    end

    drain();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("edge_normalized_box_filter_top regression: pass");
    end else begin
      $display("edge_normalized_box_filter_top regression: fail");
    end
    $finish;
  end

endmodule
